>>> design/boot_overlay_memory_map_macros.svh
// ============================================================================
// Boot overlay memory map - assertion macros
// Shared concurrent assertion forms for the port checker of the memory map.
// ============================================================================
`ifndef BOOT_OVERLAY_MEMORY_MAP_MACROS_SVH
`define BOOT_OVERLAY_MEMORY_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bomm_pkg.sv
// ============================================================================
// Boot overlay memory map - package
// Types, map constants and the window wrap helper shared by the design.
// ============================================================================
package bomm_pkg;

   // Access kinds carried in req_tuser.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Beat widths.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // Fixed store depths.
   localparam int BOOT_DEPTH = 256;
   localparam int ROM_DEPTH  = 32768;
   localparam int OAM_DEPTH  = 160;
   localparam int HRAM_DEPTH = 128;

   // Defaults for the sizable RAM windows.
   localparam int VRAM_DEPTH_DEFAULT = 8192;
   localparam int ERAM_DEPTH_DEFAULT = 8192;
   localparam int WRAM_DEPTH_DEFAULT = 8192;

   // Map boundaries.
   localparam logic [15:0] PC_BOOT_EXIT = 16'h0100;
   localparam logic [15:0] OAM_BASE     = 16'hFE00;
   localparam logic [15:0] HOLE_BASE    = 16'hFEA0;
   localparam logic [15:0] HRAM_BASE    = 16'hFF80;

   typedef enum logic [2:0] {
      REGION_BOOT,
      REGION_ROM,
      REGION_VRAM,
      REGION_ERAM,
      REGION_WRAM,
      REGION_OAM,
      REGION_HRAM,
      REGION_HOLE
   } region_type;

   // Decoder result handed to the storage side.
   typedef struct packed {
      region_type region;
      logic       boot_next;
   } decode_type;

   // Wraps a 13-bit window offset into a RAM of the given depth (1024 to 8192).
   // The quotient is below eight, so three restoring steps suffice.
   function automatic logic [12:0] window_wrap(input logic [12:0] offset,
                                               input int unsigned depth);
      logic [15:0] value;
      logic [15:0] step;
      value = {3'b000, offset};
      for (int k = 2; k >= 0; k--) begin
         step = 16'(depth << k);
         if (value >= step) begin
            value = value - step;
         end
      end
      return value[12:0];
   endfunction

endpackage

>>> design/bomm_decode.sv
// ============================================================================
// Boot overlay memory map - address decoder
// Maps a bus address onto a store and works out the boot flag after the beat.
// ============================================================================
module bomm_decode (
   input  logic                op,
   input  logic [15:0]         address,
   input  logic [15:0]         current_pc,
   input  logic                boot_active,
   output bomm_pkg::decode_type decode
);
   import bomm_pkg::*;

   logic boot_exit;
   logic boot_next;

   // A read of the first 4 KiB with the pc at the cartridge entry ends the boot phase.
   assign boot_exit = (op == OP_READ) && (address[15:12] == 4'h0) &&
                      (current_pc == PC_BOOT_EXIT);

   assign boot_next = boot_active && !boot_exit;

   // Region select, following the map from the bottom up.
   always_comb begin
      decode.boot_next = boot_next;
      if (!address[15]) begin
         if (boot_next && (address[15:8] == 8'h00)) begin
            decode.region = REGION_BOOT;
         end else begin
            decode.region = REGION_ROM;
         end
      end else if (address[15:13] == 3'b100) begin
         decode.region = REGION_VRAM;
      end else if (address[15:13] == 3'b101) begin
         decode.region = REGION_ERAM;
      end else if (address < OAM_BASE) begin
         decode.region = REGION_WRAM;
      end else if (address < HOLE_BASE) begin
         decode.region = REGION_OAM;
      end else if (address >= HRAM_BASE) begin
         decode.region = REGION_HRAM;
      end else begin
         decode.region = REGION_HOLE;
      end
   end

endmodule

>>> design/boot_overlay_memory_map.sv
// ============================================================================
// Boot overlay memory map - top level
// Decodes one byte access per beat onto boot ROM, ROM, video, external,
// work, sprite attribute and high RAM, with the boot ROM overlay.
// ============================================================================
// Takes one read or write beat per clock unless the result side stalls, and
// returns exactly one result beat per request in the cycle after acceptance,
// through the registered read port of the stores. A new request is taken
// whenever the result register is empty or being emptied in the same cycle, so
// a steady stream runs at one beat per cycle. The boot ROM overlays 0x0000-0x00FF
// until a read below 0x1000 is made with the pc at 0x0100. Reads of 0xFEA0-0xFF7F
// return zero with the unmapped flag set and writes there are dropped. Store
// contents are undefined until written; there is no clearing pass after reset.
module boot_overlay_memory_map #(
   parameter int VRAM_DEPTH = bomm_pkg::VRAM_DEPTH_DEFAULT,
   parameter int ERAM_DEPTH = bomm_pkg::ERAM_DEPTH_DEFAULT,
   parameter int WRAM_DEPTH = bomm_pkg::WRAM_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address [15:0], write_data [23:16], current_pc [39:24]
   input  logic [bomm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // op [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data [7:0]
   output logic [7:0]                         rsp_tdata,
   // unmapped [0], boot_visible [1]
   output logic [bomm_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import bomm_pkg::*;

   localparam int VRAM_AW = $clog2(VRAM_DEPTH);
   localparam int ERAM_AW = $clog2(ERAM_DEPTH);
   localparam int WRAM_AW = $clog2(WRAM_DEPTH);

   logic [15:0]  address;
   logic [7:0]   write_data;
   logic [15:0]  current_pc;
   logic         accept;
   logic         rd_en;
   logic         wr_en;
   decode_type   decode;

   logic [VRAM_AW-1:0] vram_idx;
   logic [ERAM_AW-1:0] eram_idx;
   logic [WRAM_AW-1:0] wram_idx;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         boot_ff;
   logic         boot_in;
   region_type   region_ff;
   logic         write_ff;

   logic [7:0]   boot_rd_ff;
   logic [7:0]   rom_rd_ff;
   logic [7:0]   vram_rd_ff;
   logic [7:0]   eram_rd_ff;
   logic [7:0]   wram_rd_ff;
   logic [7:0]   oam_rd_ff;
   logic [7:0]   hram_rd_ff;

   logic [7:0]   boot_mem [BOOT_DEPTH];
   logic [7:0]   rom_mem  [ROM_DEPTH];
   logic [7:0]   vram_mem [VRAM_DEPTH];
   logic [7:0]   eram_mem [ERAM_DEPTH];
   logic [7:0]   wram_mem [WRAM_DEPTH];
   logic [7:0]   oam_mem  [OAM_DEPTH];
   logic [7:0]   hram_mem [HRAM_DEPTH];

   // Unpack the request beat.
   assign address    = req_tdata[15:0];
   assign write_data = req_tdata[23:16];
   assign current_pc = req_tdata[39:24];

   // The result register frees up when empty or when its beat is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept && (req_tuser == OP_READ);
   assign wr_en      = accept && (req_tuser == OP_WRITE);

   bomm_decode u_decode (
      .op          (req_tuser),
      .address     (address),
      .current_pc  (current_pc),
      .boot_active (boot_ff),
      .decode      (decode)
   );

   // Window offsets wrapped into each RAM's depth.
   assign vram_idx = VRAM_AW'(window_wrap(address[12:0], VRAM_DEPTH));
   assign eram_idx = ERAM_AW'(window_wrap(address[12:0], ERAM_DEPTH));
   assign wram_idx = WRAM_AW'(window_wrap(address[12:0], WRAM_DEPTH));

   // Control state: result valid and the boot overlay flag.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign boot_in      = accept ? decode.boot_next : boot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         boot_ff      <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         boot_ff      <= boot_in;
      end
   end

   // Result side information, loaded with each accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         region_ff <= decode.region;
         write_ff  <= wr_en;
      end
   end

   // Boot ROM store.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_BOOT) begin
         if (wr_en) begin
            boot_mem[address[7:0]] <= write_data;
         end
         if (rd_en) begin
            boot_rd_ff <= boot_mem[address[7:0]];
         end
      end
   end

   // Cartridge ROM store.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_ROM) begin
         if (wr_en) begin
            rom_mem[address[14:0]] <= write_data;
         end
         if (rd_en) begin
            rom_rd_ff <= rom_mem[address[14:0]];
         end
      end
   end

   // Video RAM.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_VRAM) begin
         if (wr_en) begin
            vram_mem[vram_idx] <= write_data;
         end
         if (rd_en) begin
            vram_rd_ff <= vram_mem[vram_idx];
         end
      end
   end

   // External RAM.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_ERAM) begin
         if (wr_en) begin
            eram_mem[eram_idx] <= write_data;
         end
         if (rd_en) begin
            eram_rd_ff <= eram_mem[eram_idx];
         end
      end
   end

   // Work RAM, including its echo.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_WRAM) begin
         if (wr_en) begin
            wram_mem[wram_idx] <= write_data;
         end
         if (rd_en) begin
            wram_rd_ff <= wram_mem[wram_idx];
         end
      end
   end

   // Sprite attribute RAM; the decoder keeps the low byte below 0xA0.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_OAM) begin
         if (wr_en) begin
            oam_mem[address[7:0]] <= write_data;
         end
         if (rd_en) begin
            oam_rd_ff <= oam_mem[address[7:0]];
         end
      end
   end

   // High RAM.
   always_ff @(posedge clock) begin
      if (decode.region == REGION_HRAM) begin
         if (wr_en) begin
            hram_mem[address[6:0]] <= write_data;
         end
         if (rd_en) begin
            hram_rd_ff <= hram_mem[address[6:0]];
         end
      end
   end

   // Result beat: pick the store that answered; writes and the hole read as zero.
   always_comb begin
      rsp_tdata = 8'h00;
      if (!write_ff) begin
         case (region_ff)
            REGION_BOOT: rsp_tdata = boot_rd_ff;
            REGION_ROM:  rsp_tdata = rom_rd_ff;
            REGION_VRAM: rsp_tdata = vram_rd_ff;
            REGION_ERAM: rsp_tdata = eram_rd_ff;
            REGION_WRAM: rsp_tdata = wram_rd_ff;
            REGION_OAM:  rsp_tdata = oam_rd_ff;
            REGION_HRAM: rsp_tdata = hram_rd_ff;
            default:     rsp_tdata = 8'h00;
         endcase
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = (region_ff == REGION_HOLE);
   assign rsp_tuser[1] = boot_ff;

endmodule

>>> design/bomm_checker.sv
// ============================================================================
// Boot overlay memory map - port checker
// Watches the request and result beats of the memory map over time.
// ============================================================================
`include "boot_overlay_memory_map_macros.svh"

module bomm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [7:0]                       rsp_tdata,
   input logic [bomm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import bomm_pkg::*;

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Every accepted request shows its result in the following cycle.
   `BOMM_ASSERT_NEXT(a_result_follows, clock, reset, req_beat, rsp_tvalid, "request beat without a result beat")

   // A write always reports a zero data byte.
   `BOMM_ASSERT_NEXT(a_write_reads_zero, clock, reset, req_beat && (req_tuser == OP_WRITE), rsp_tdata == 8'h00, "write beat returned non-zero data")

   // Once the overlay is off it stays off until reset.
   `BOMM_ASSERT_NEXT(a_boot_stays_off, clock, reset, rsp_beat && !rsp_tuser[1], !(rsp_tvalid && rsp_tuser[1]), "boot overlay came back on")

   // A stalled result beat holds still.
   `BOMM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

   // A hole access reports zero data.
   `BOMM_ASSERT_SAME(a_hole_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 8'h00, "unmapped beat returned data")

endmodule

bind boot_overlay_memory_map bomm_checker u_bomm_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Boot overlay memory map - testbench
// Drives byte reads and writes across the whole 16-bit map, keeps a shadow of
// every store and of the boot flag, and checks each result beat against it.
// ============================================================================
module testbench;

   import bomm_pkg::*;

   // One request beat and one result beat, in field order.
   typedef struct packed {
      logic        op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [15:0] current_pc;
   } access_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       unmapped;
      logic       boot_visible;
   } result_type;

   typedef struct packed {
      access_type access;
      logic       typed;
      result_type want;
   } directed_row_type;

   localparam logic [15:0] BOOT_WINDOW_END = 16'h0100;
   localparam logic [15:0] EXIT_WINDOW_END = 16'h1000;
   localparam logic [15:0] VRAM_BASE       = 16'h8000;
   localparam logic [15:0] ERAM_BASE       = 16'hA000;
   localparam logic [15:0] WRAM_BASE       = 16'hC000;
   localparam int          SHADOW_SIZE     = 8 * 32768;
   localparam int          HOLD_CYCLES     = 250;
   localparam int          RANDOM_PHASES   = 4;
   localparam int          BEATS_PER_PHASE = 185;
   localparam int          HISTORY_DEPTH   = 2048;
   localparam int          DIRECTED_ROWS   = 25;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = OP_READ;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // Shadow of the map: one flat byte array indexed by region and offset.
   logic [7:0]  shadow_data    [0:SHADOW_SIZE-1];
   bit          shadow_written [0:SHADOW_SIZE-1];
   bit          boot_overlay = 1'b1;
   logic [15:0] written_addresses [$];
   result_type  pending_results [$];

   int unsigned error_count  = 0;
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;
   int unsigned holds_asked  = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left    = 0;

   // Directed beats: boot window, map edges, echo, hole, top byte, boot exit.
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{'{OP_WRITE, 16'h0000, 8'hA5, 16'h0000}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_WRITE, 16'h00FF, 8'h5A, 16'hFFFF}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_READ,  16'h0000, 8'hFF, 16'hFFFF}, 1'b1, '{8'hA5, 1'b0, 1'b1}},
      '{'{OP_READ,  16'h00FF, 8'h00, 16'h0000}, 1'b1, '{8'h5A, 1'b0, 1'b1}},
      '{'{OP_WRITE, 16'h0100, 8'h3C, 16'h0100}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_WRITE, 16'h0FFF, 8'hC3, 16'h0000}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_WRITE, 16'h7FFF, 8'h81, 16'h0000}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{'{OP_READ,  16'h7FFF, 8'h00, 16'h0100}, 1'b1, '{8'h81, 1'b0, 1'b1}},
      '{'{OP_WRITE, 16'h8000, 8'h11, 16'h1234}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'h9FFF, 8'h22, 16'h4321}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hA000, 8'h33, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hBFFF, 8'h44, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hC000, 8'h55, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hFDFF, 8'h66, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_READ,  16'hDDFF, 8'h00, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_READ,  16'hE000, 8'h00, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hFE00, 8'h77, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_WRITE, 16'hFE9F, 8'h88, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_READ,  16'hFE9F, 8'h00, 16'h0000}, 1'b1, '{8'h88, 1'b0, 1'b1}},
      '{'{OP_READ,  16'hFEA0, 8'h00, 16'h0000}, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{'{OP_WRITE, 16'hFF7F, 8'hFF, 16'h0000}, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{'{OP_WRITE, 16'hFFFF, 8'h99, 16'h0000}, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{'{OP_READ,  16'hFFFF, 8'h00, 16'h0000}, 1'b1, '{8'h99, 1'b0, 1'b1}},
      '{'{OP_READ,  16'h0FFF, 8'h00, 16'h0100}, 1'b1, '{8'hC3, 1'b0, 1'b0}},
      '{'{OP_READ,  16'h0100, 8'h00, 16'h0100}, 1'b1, '{8'h3C, 1'b0, 1'b0}}
   };

   boot_overlay_memory_map u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Finds the byte an address selects; the shadow index is region then offset.
   function automatic int unsigned shadow_index(input logic [15:0] address,
                                                input bit overlay_on,
                                                output region_type region);
      logic [14:0] offset;
      offset = '0;
      if (address < VRAM_BASE) begin
         if (overlay_on && address < BOOT_WINDOW_END) begin
            region = REGION_BOOT;
            offset = 15'(address[7:0]);
         end else begin
            region = REGION_ROM;
            offset = address[14:0];
         end
      end else if (address < ERAM_BASE) begin
         region = REGION_VRAM;
         offset = 15'(address[12:0]);
      end else if (address < WRAM_BASE) begin
         region = REGION_ERAM;
         offset = 15'(address[12:0]);
      end else if (address < OAM_BASE) begin
         region = REGION_WRAM;
         offset = 15'(address[12:0]);
      end else if (address < HOLE_BASE) begin
         region = REGION_OAM;
         offset = 15'(address[7:0]);
      end else if (address >= HRAM_BASE) begin
         region = REGION_HRAM;
         offset = 15'(address[6:0]);
      end else begin
         region = REGION_HOLE;
      end
      return 32'({region, offset});
   endfunction

   // The boot flag once this access has been seen: only a read in the low
   // 4 KiB with the pc at the exit point clears it.
   function automatic bit overlay_after(input access_type access);
      if (access.op == OP_READ && access.address < EXIT_WINDOW_END &&
          access.current_pc == PC_BOOT_EXIT) begin
         return 1'b0;
      end
      return boot_overlay;
   endfunction

   // A read may only land on a byte that has been written, or on the hole.
   function automatic bit read_is_defined(input access_type access);
      region_type  region;
      int unsigned index;
      index = shadow_index(access.address, overlay_after(access), region);
      return region == REGION_HOLE || shadow_written[index];
   endfunction

   // Applies one accepted access to the shadow map and returns its result.
   function automatic result_type map_access(input access_type access);
      region_type  region;
      int unsigned index;
      result_type  outcome;
      boot_overlay = overlay_after(access);
      index = shadow_index(access.address, boot_overlay, region);
      outcome = '{8'h00, region == REGION_HOLE, boot_overlay};
      if (region != REGION_HOLE) begin
         if (access.op == OP_READ) begin
            outcome.read_data = shadow_data[index];
         end else begin
            shadow_data[index] = access.write_data;
            shadow_written[index] = 1'b1;
            written_addresses.push_back(access.address);
            if (written_addresses.size() > HISTORY_DEPTH) begin
               void'(written_addresses.pop_front());
            end
         end
      end
      return outcome;
   endfunction

   // Picks a region at random, then an address inside it.
   function automatic logic [15:0] random_address();
      case ($urandom_range(9))
         0, 1:    return 16'($urandom_range(16'h0000, 16'h7FFF));
         2:       return 16'($urandom_range(16'h8000, 16'h9FFF));
         3:       return 16'($urandom_range(16'hA000, 16'hBFFF));
         4:       return 16'($urandom_range(16'hC000, 16'hDFFF));
         5:       return 16'($urandom_range(16'hE000, 16'hFDFF));
         6:       return 16'($urandom_range(16'hFE00, 16'hFE9F));
         7:       return 16'($urandom_range(16'hFEA0, 16'hFF7F));
         8:       return 16'($urandom_range(16'hFF80, 16'hFFFF));
         default: return 16'($urandom_range(16'h0000, 16'h0FFF));
      endcase
   endfunction

   // Most reads revisit written bytes, work RAM ones often through the echo.
   // A read that would land on an unwritten byte is turned into a write.
   function automatic access_type random_access();
      access_type access;
      access.op = $urandom_range(1) ? OP_WRITE : OP_READ;
      access.write_data = 8'($urandom);
      access.current_pc = ($urandom_range(15) == 0) ? PC_BOOT_EXIT : 16'($urandom);
      if (access.op == OP_READ && written_addresses.size() != 0 &&
          $urandom_range(4) != 0) begin
         access.address = written_addresses[$urandom_range(written_addresses.size() - 1)];
         if ($urandom_range(1)) begin
            if (access.address >= WRAM_BASE && access.address < 16'hDE00) begin
               access.address = access.address + 16'h2000;
            end else if (access.address >= 16'hE000 && access.address < OAM_BASE) begin
               access.address = access.address - 16'h2000;
            end
         end
      end else begin
         access.address = random_address();
      end
      if (access.op == OP_READ && !read_is_defined(access)) begin
         access.op = OP_WRITE;
      end
      return access;
   endfunction

   // Offers one beat, with random gaps in front, and records its expectation.
   task automatic send_access(input access_type access, input logic typed,
                              input result_type want);
      result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {access.current_pc, access.write_data, access.address};
      req_tuser  <= access.op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = map_access(access);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Holds the sender back until every outstanding result has come.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Receiver: random stalls, plus long hold-offs counted here on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Checks each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1]};
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing expected: %p", $time, got);
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
               error_count++;
               $display("%0t: read_data expected %h, got %h",
                        $time, want.read_data, got.read_data);
            end
            if (got.unmapped !== want.unmapped) begin
               error_count++;
               $display("%0t: unmapped expected %b, got %b",
                        $time, want.unmapped, got.unmapped);
            end
            if (got.boot_visible !== want.boot_visible) begin
               error_count++;
               $display("%0t: boot_visible expected %b, got %b",
                        $time, want.boot_visible, got.boot_visible);
            end
         end
      end
   end

   // Stimulus: reset, directed beats, then random phases with varied idling.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[row]) begin
         send_access(directed_rows[row].access, directed_rows[row].typed,
                     directed_rows[row].want);
      end
      wait_for_drain();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin send_gap_pct = 0;  stall_pct = 0;  end
            1:       begin send_gap_pct = 59; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 59; end
            default: begin send_gap_pct = 8;  stall_pct = 8;  end
         endcase
         // The receiver backs off for a long stretch while beats keep coming.
         if (phase == 2) begin
            holds_asked <= holds_asked + 1;
         end
         for (int beat = 0; beat < BEATS_PER_PHASE; beat++) begin
            send_access(random_access(), 1'b0, '0);
         end
         wait_for_drain();
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[boot_overlay_memory_map] OK");
      end else begin
         $display("[boot_overlay_memory_map] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("[boot_overlay_memory_map] ERROR");
      $finish;
   end

endmodule
